// ----- src/scc_pkg.sv -----
// Shared widths, command and color codes, and the vertex record type for the SCC second-pass search.
// No dependencies; every other file refers to it by scoped names.
package scc_pkg;

  localparam int VTX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int TIME_W = 8;

  localparam logic [1:0] CMD_ADD_EDGE = 2'd0;
  localparam logic [1:0] CMD_PUSH     = 2'd1;
  localparam logic [1:0] CMD_RUN      = 2'd2;

  localparam logic [1:0] COLOR_WHITE = 2'd0;
  localparam logic [1:0] COLOR_GRAY  = 2'd1;
  localparam logic [1:0] COLOR_BLACK = 2'd2;

  localparam logic [7:0] NO_PARENT = 8'hFF;

  typedef struct packed {
    logic [TIME_W-1:0] disc;
    logic [CNT_W-1:0]  par;
    logic [VTX_W-1:0]  root;
  } vrec_t;

endpackage

// ----- src/scc_chan_if.sv -----
// Channel interfaces: command items in, per-vertex results out, and the vertex count write.
// Depends on scc_pkg for field widths.
interface scc_item_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic [scc_pkg::VTX_W-1:0] vertex_a;
  logic [scc_pkg::VTX_W-1:0] vertex_b;
  modport source (output valid, command, vertex_a, vertex_b, input ready);
  modport sink   (input valid, command, vertex_a, vertex_b, output ready);
endinterface

interface scc_result_if;
  logic                       valid;
  logic                       ready;
  logic [scc_pkg::CNT_W-1:0]  vertex_number;
  logic [1:0]                 final_color;
  logic [scc_pkg::TIME_W-1:0] discover_time;
  logic [scc_pkg::TIME_W-1:0] finish_time;
  logic signed [7:0]          parent_vertex;
  logic [scc_pkg::CNT_W-1:0]  root_vertex;
  logic                       overflow;
  logic                       last;
  modport source (output valid, vertex_number, final_color, discover_time, finish_time,
                  parent_vertex, root_vertex, overflow, last, input ready);
  modport sink   (input valid, vertex_number, final_color, discover_time, finish_time,
                  parent_vertex, root_vertex, overflow, last, output ready);
endinterface

interface scc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [scc_pkg::CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- src/scc_second_pass_dfs.sv -----
// Top level: edge list loader, finish-order stack and the memory-based depth-first search.
// Depends on scc_pkg and the channel interfaces in scc_chan_if.sv.
// Add edge and push beats are accepted one per cycle while the block is idle. Run steps, paced
// by the one-read-per-cycle head, edge and walk memories: pop POP_RD, POP_CHK; edge visit HEAD_RD,
// HEAD_CHK, EDGE; finish HEAD_RD, HEAD_CHK, TOP or POP_RD; each result EMIT_RD, EMIT_LD, EMIT_OUT.
// Intake stalls from the run beat until the last result beat is taken.
// Reset clears lists, stack, counters and colors at once through valid bits; no clearing pass.
module scc_second_pass_dfs #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scc_item_if.sink    in_i,
  scc_result_if.source out_o,
  scc_cfg_if.sink     cfg_i
);

  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int VW  = scc_pkg::VTX_W;
  localparam int NW  = scc_pkg::CNT_W;
  localparam int TW  = scc_pkg::TIME_W;
  localparam int EMW = VW + ETW;
  localparam logic [NW-1:0]  MAXV_N = NW'(MAX_VERTICES);
  localparam logic [CW-1:0]  MAXV_C = CW'(MAX_VERTICES);
  localparam logic [ETW-1:0] MAXE   = ETW'(MAX_EDGES);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_POP_RD   = 4'd1;
  localparam logic [3:0] S_POP_CHK  = 4'd2;
  localparam logic [3:0] S_HEAD_RD  = 4'd3;
  localparam logic [3:0] S_HEAD_CHK = 4'd4;
  localparam logic [3:0] S_EDGE     = 4'd5;
  localparam logic [3:0] S_TOP      = 4'd6;
  localparam logic [3:0] S_EMIT_RD  = 4'd7;
  localparam logic [3:0] S_EMIT_LD  = 4'd8;
  localparam logic [3:0] S_EMIT_OUT = 4'd9;

  logic [3:0]              state_q, state_d;
  logic [ETW-1:0]          etot_q, etot_d;
  logic [CW-1:0]           fcnt_q, fcnt_d;
  logic                    drop_q, drop_d;
  logic [NW-1:0]           n_q, n_d;
  logic                    pv_q, pv_d;
  logic [VW-1:0]           pa_q, pa_d, pb_q, pb_d;
  logic [ETW-1:0]          pidx_q, pidx_d;
  logic                    fwd_q, fwd_d;
  logic [ETW-1:0]          fwdv_q, fwdv_d;
  logic [MAX_VERTICES-1:0] hv_q, hv_d, vis_q, vis_d, blk_q, blk_d;
  logic [VW-1:0]           cur_q, cur_d, root_q, root_d;
  logic [CW-1:0]           dep_q, dep_d;
  logic [TW-1:0]           time_q, time_d;
  logic [NW-1:0]           idx_q, idx_d;

  logic [NW-1:0]           o_num_q, o_num_d, o_root_q, o_root_d;
  logic [1:0]              o_col_q, o_col_d;
  logic [TW-1:0]           o_disc_q, o_disc_d, o_fin_q, o_fin_d;
  logic [7:0]              o_par_q, o_par_d;
  logic                    o_ovf_q, o_ovf_d, o_last_q, o_last_d;

  logic [ETW-1:0] hd_mem [MAX_VERTICES];
  logic [EMW-1:0] em_mem [MAX_EDGES];
  logic [VW-1:0]  fs_mem [MAX_VERTICES];
  logic [VW-1:0]  wk_mem [MAX_VERTICES];
  scc_pkg::vrec_t vm_mem [MAX_VERTICES];
  logic [TW-1:0]  fm_mem [MAX_VERTICES];

  logic           hd_we;
  logic [VIW-1:0] hd_waddr, hd_raddr;
  logic [ETW-1:0] hd_wdata, hd_rd_q;
  logic           hv_rd_q;
  logic           em_we;
  logic [EAW-1:0] em_waddr, em_raddr;
  logic [EMW-1:0] em_wdata, em_rd_q;
  logic           fs_we;
  logic [VIW-1:0] fs_waddr, fs_raddr;
  logic [VW-1:0]  fs_wdata, fs_rd_q;
  logic           wk_we;
  logic [VIW-1:0] wk_waddr, wk_raddr;
  logic [VW-1:0]  wk_wdata, wk_rd_q;
  logic           vm_we;
  logic [VIW-1:0] vm_waddr, vr_addr;
  scc_pkg::vrec_t vm_wdata, vm_rd_q;
  logic           fm_we;
  logic [VIW-1:0] fm_waddr;
  logic [TW-1:0]  fm_wdata, fm_rd_q;

  logic           in_fire, out_fire;
  logic [ETW-1:0] old_head, h, hm1, e_link;
  logic [CW-1:0]  fcm1, depm2;
  logic [VW-1:0]  e_tgt;
  logic [NW-1:0]  cfg_v, idx_p1;
  logic           e_vis, v_vis;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_o.valid && out_o.ready;

  assign out_o.valid         = (state_q == S_EMIT_OUT);
  assign out_o.vertex_number = o_num_q;
  assign out_o.final_color   = o_col_q;
  assign out_o.discover_time = o_disc_q;
  assign out_o.finish_time   = o_fin_q;
  assign out_o.parent_vertex = o_par_q;
  assign out_o.root_vertex   = o_root_q;
  assign out_o.overflow      = o_ovf_q;
  assign out_o.last          = o_last_q;

  assign old_head = fwd_q ? fwdv_q : (hv_rd_q ? hd_rd_q : '0);
  assign h        = hv_rd_q ? hd_rd_q : '0;
  assign hm1      = h - ETW'(1);
  assign fcm1     = fcnt_q - CW'(1);
  assign depm2    = dep_q - CW'(2);
  assign e_tgt    = em_rd_q[EMW-1:ETW];
  assign e_link   = em_rd_q[ETW-1:0];
  assign idx_p1   = idx_q + NW'(1);

  always_comb begin
    state_d = state_q;
    etot_d  = etot_q;
    fcnt_d  = fcnt_q;
    drop_d  = drop_q;
    n_d     = n_q;
    pv_d    = 1'b0;
    pa_d    = pa_q;
    pb_d    = pb_q;
    pidx_d  = pidx_q;
    fwd_d   = 1'b0;
    fwdv_d  = fwdv_q;
    hv_d    = hv_q;
    vis_d   = vis_q;
    blk_d   = blk_q;
    cur_d   = cur_q;
    root_d  = root_q;
    dep_d   = dep_q;
    time_d  = time_q;
    idx_d   = idx_q;
    o_num_d  = o_num_q;
    o_col_d  = o_col_q;
    o_disc_d = o_disc_q;
    o_fin_d  = o_fin_q;
    o_par_d  = o_par_q;
    o_root_d = o_root_q;
    o_ovf_d  = o_ovf_q;
    o_last_d = o_last_q;

    hd_we = 1'b0; hd_waddr = pa_q[VIW-1:0]; hd_wdata = pidx_q + ETW'(1);
    hd_raddr = cur_q[VIW-1:0];
    em_we = 1'b0; em_waddr = pidx_q[EAW-1:0]; em_wdata = {pb_q, old_head};
    em_raddr = hm1[EAW-1:0];
    fs_we = 1'b0; fs_waddr = fcnt_q[VIW-1:0]; fs_wdata = in_i.vertex_a;
    fs_raddr = fcm1[VIW-1:0];
    wk_we = 1'b0; wk_waddr = dep_q[VIW-1:0]; wk_wdata = e_tgt;
    wk_raddr = depm2[VIW-1:0];
    vm_we = 1'b0; vm_waddr = e_tgt[VIW-1:0];
    vm_wdata = '{disc: time_q, par: {1'b0, cur_q} + NW'(1), root: root_q};
    fm_we = 1'b0; fm_waddr = cur_q[VIW-1:0]; fm_wdata = time_q;
    vr_addr = idx_q[VIW-1:0];
    e_vis = 1'b0;
    v_vis = 1'b0;

    cfg_v = cfg_i.data;
    if (cfg_i.valid) begin
      if (cfg_v == '0) begin
        n_d = NW'(1);
      end else if (cfg_v > MAXV_N) begin
        n_d = MAXV_N;
      end else begin
        n_d = cfg_v;
      end
    end

    if (pv_q) begin
      em_we = 1'b1;
      hd_we = 1'b1;
      hv_d[pa_q[VIW-1:0]] = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        hd_raddr = in_i.vertex_a[VIW-1:0];
        if (in_fire) begin
          case (in_i.command)
            scc_pkg::CMD_ADD_EDGE: begin
              if ({1'b0, in_i.vertex_a} < MAXV_N && {1'b0, in_i.vertex_b} < MAXV_N) begin
                if (etot_q >= MAXE) begin
                  drop_d = 1'b1;
                end else begin
                  pv_d   = 1'b1;
                  pa_d   = in_i.vertex_a;
                  pb_d   = in_i.vertex_b;
                  pidx_d = etot_q;
                  etot_d = etot_q + ETW'(1);
                  fwd_d  = pv_q && (pa_q == in_i.vertex_a);
                  fwdv_d = pidx_q + ETW'(1);
                end
              end
            end
            scc_pkg::CMD_PUSH: begin
              if ({1'b0, in_i.vertex_a} < MAXV_N) begin
                if (fcnt_q >= MAXV_C) begin
                  drop_d = 1'b1;
                end else begin
                  fs_we  = 1'b1;
                  fcnt_d = fcnt_q + CW'(1);
                end
              end
            end
            scc_pkg::CMD_RUN: begin
              vis_d   = '0;
              blk_d   = '0;
              time_d  = TW'(1);
              dep_d   = '0;
              state_d = S_POP_RD;
            end
            default: begin
            end
          endcase
        end
      end
      S_POP_RD: begin
        if (fcnt_q == '0) begin
          idx_d   = '0;
          state_d = S_EMIT_RD;
        end else begin
          state_d = S_POP_CHK;
        end
      end
      S_POP_CHK: begin
        fcnt_d  = fcm1;
        state_d = S_POP_RD;
        v_vis = vis_q[fs_rd_q[VIW-1:0]];
        if ({1'b0, fs_rd_q} < n_q && !v_vis) begin
          vis_d[fs_rd_q[VIW-1:0]] = 1'b1;
          vm_we    = 1'b1;
          vm_waddr = fs_rd_q[VIW-1:0];
          vm_wdata = '{disc: time_q, par: '0, root: fs_rd_q};
          wk_we    = 1'b1;
          wk_waddr = '0;
          wk_wdata = fs_rd_q;
          time_d   = time_q + TW'(1);
          cur_d    = fs_rd_q;
          root_d   = fs_rd_q;
          dep_d    = CW'(1);
          state_d  = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        state_d = S_HEAD_CHK;
      end
      S_HEAD_CHK: begin
        if (h != '0) begin
          state_d = S_EDGE;
        end else begin
          blk_d[cur_q[VIW-1:0]] = 1'b1;
          fm_we  = 1'b1;
          time_d = time_q + TW'(1);
          dep_d  = dep_q - CW'(1);
          if (dep_q == CW'(1)) begin
            state_d = S_POP_RD;
          end else begin
            state_d = S_TOP;
          end
        end
      end
      S_EDGE: begin
        hd_we    = 1'b1;
        hd_waddr = cur_q[VIW-1:0];
        hd_wdata = e_link;
        state_d  = S_HEAD_RD;
        e_vis = vis_q[e_tgt[VIW-1:0]];
        if ({1'b0, e_tgt} < n_q && !e_vis && dep_q < MAXV_C) begin
          vis_d[e_tgt[VIW-1:0]] = 1'b1;
          vm_we  = 1'b1;
          wk_we  = 1'b1;
          time_d = time_q + TW'(1);
          dep_d  = dep_q + CW'(1);
          cur_d  = e_tgt;
        end
      end
      S_TOP: begin
        cur_d   = wk_rd_q;
        state_d = S_HEAD_RD;
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        v_vis    = vis_q[idx_q[VIW-1:0]];
        o_num_d  = idx_p1;
        o_col_d  = !v_vis ? scc_pkg::COLOR_WHITE :
                   (blk_q[idx_q[VIW-1:0]] ? scc_pkg::COLOR_BLACK : scc_pkg::COLOR_GRAY);
        o_disc_d = v_vis ? vm_rd_q.disc : '0;
        o_fin_d  = blk_q[idx_q[VIW-1:0]] ? fm_rd_q : '0;
        o_par_d  = (!v_vis || vm_rd_q.par == '0) ? scc_pkg::NO_PARENT : {1'b0, vm_rd_q.par};
        o_root_d = v_vis ? ({1'b0, vm_rd_q.root} + NW'(1)) : idx_p1;
        o_ovf_d  = drop_q;
        o_last_d = (idx_p1 == n_q);
        state_d  = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_o.ready) begin
          if (o_last_q) begin
            hv_d    = '0;
            etot_d  = '0;
            fcnt_d  = '0;
            drop_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_p1;
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      etot_q  <= '0;
      fcnt_q  <= '0;
      drop_q  <= 1'b0;
      n_q     <= MAXV_N;
      pv_q    <= 1'b0;
      fwd_q   <= 1'b0;
      hv_q    <= '0;
      vis_q   <= '0;
      blk_q   <= '0;
      dep_q   <= '0;
      time_q  <= TW'(1);
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      etot_q  <= etot_d;
      fcnt_q  <= fcnt_d;
      drop_q  <= drop_d;
      n_q     <= n_d;
      pv_q    <= pv_d;
      fwd_q   <= fwd_d;
      hv_q    <= hv_d;
      vis_q   <= vis_d;
      blk_q   <= blk_d;
      dep_q   <= dep_d;
      time_q  <= time_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q     <= pa_d;
    pb_q     <= pb_d;
    pidx_q   <= pidx_d;
    fwdv_q   <= fwdv_d;
    cur_q    <= cur_d;
    root_q   <= root_d;
    o_num_q  <= o_num_d;
    o_col_q  <= o_col_d;
    o_disc_q <= o_disc_d;
    o_fin_q  <= o_fin_d;
    o_par_q  <= o_par_d;
    o_root_q <= o_root_d;
    o_ovf_q  <= o_ovf_d;
    o_last_q <= o_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (hd_we) begin
      hd_mem[hd_waddr] <= hd_wdata;
    end
    hd_rd_q <= hd_mem[hd_raddr];
    hv_rd_q <= hv_q[hd_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (em_we) begin
      em_mem[em_waddr] <= em_wdata;
    end
    em_rd_q <= em_mem[em_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    fs_rd_q <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wk_we) begin
      wk_mem[wk_waddr] <= wk_wdata;
    end
    wk_rd_q <= wk_mem[wk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vm_we) begin
      vm_mem[vm_waddr] <= vm_wdata;
    end
    vm_rd_q <= vm_mem[vr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fm_we) begin
      fm_mem[fm_waddr] <= fm_wdata;
    end
    fm_rd_q <= fm_mem[vr_addr];
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_o.last) |=> (etot_q == '0 && fcnt_q == '0 && !drop_q && hv_q == '0))
    else $error("loads not cleared after last result beat");
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dep_q <= MAXV_C)
    else $error("walk depth beyond vertex capacity");
  a_time_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    time_q <= TW'(2 * MAX_VERTICES + 1))
    else $error("time counter beyond two stamps per vertex");
  a_no_intake_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("intake open while results pending");
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> (out_o.vertex_number == n_q))
    else $error("last flag on wrong vertex");
`endif

endmodule
